// File: hdl/radix_digit_string_to_fixed_top_assert.svh
// assertion macros for the radix string converter
`ifndef RADIX_DIGIT_STRING_TO_FIXED_TOP_ASSERT_SVH
`define RADIX_DIGIT_STRING_TO_FIXED_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define RDSF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rdsf check failed");

// consequent must hold in the cycle after the antecedent
`define RDSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rdsf check failed");

`else

`define RDSF_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define RDSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: hdl/rdsf_pkg.sv
package rdsf_pkg;

    localparam int CHAR_W     = 8;
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 6;
    localparam int FRAC_REG_W = 63;
    localparam int FCNT_W     = 4;
    localparam int OUT_W      = 32;

    typedef logic [CHAR_W-1:0]     char_t;
    typedef logic [RADIX_W-1:0]    radix_t;
    typedef logic [DIGIT_W-1:0]    digit_t;
    typedef logic [FRAC_REG_W-1:0] frac_reg_t;
    typedef logic [FCNT_W-1:0]     fcnt_t;
    typedef logic [OUT_W-1:0]      out_word_t;

    localparam char_t  CHAR_ZERO   = 8'h30;
    localparam char_t  CHAR_NINE   = 8'h39;
    localparam char_t  CHAR_UPPER_A = 8'h41;
    localparam char_t  CHAR_UPPER_Z = 8'h5A;
    localparam char_t  CHAR_POINT  = 8'h2E;

    localparam digit_t DIGIT_NONE  = 6'd36;
    localparam digit_t DEC_DIGITS  = 6'd10;
    localparam radix_t RADIX_MIN   = 6'd2;
    localparam radix_t RADIX_MAX   = 6'd36;
    localparam radix_t RADIX_RESET = 6'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DINIT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic div_init;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic div_done;
        logic out_busy;
    } stat_t;

    // value of a digit character, DIGIT_NONE for anything else
    function automatic digit_t digit_of(input char_t c);
        digit_t d;
        d = DIGIT_NONE;
        if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
            d = digit_t'(c - CHAR_ZERO);
        end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            d = digit_t'(c - CHAR_UPPER_A) + DEC_DIGITS;
        end
        return d;
    endfunction

    function automatic radix_t clamp_radix(input radix_t r);
        radix_t e;
        e = r;
        if (r < RADIX_MIN) begin
            e = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            e = RADIX_MAX;
        end
        return e;
    endfunction

endpackage

// File: hdl/rdsf_ctrl.sv
module rdsf_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  rdsf_pkg::stat_t stat,
    output rdsf_pkg::cmd_t  cmd
);

    rdsf_pkg::state_t state_reg;
    rdsf_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rdsf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rdsf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = rdsf_pkg::ST_MUL;
                end
            end
            rdsf_pkg::ST_MUL: begin
                state_next = rdsf_pkg::ST_ACC;
            end
            rdsf_pkg::ST_ACC: begin
                state_next = stat.last ? rdsf_pkg::ST_DINIT : rdsf_pkg::ST_IDLE;
            end
            rdsf_pkg::ST_DINIT: begin
                state_next = rdsf_pkg::ST_DIV;
            end
            rdsf_pkg::ST_DIV: begin
                if (stat.div_done) begin
                    state_next = rdsf_pkg::ST_OUT;
                end
            end
            rdsf_pkg::ST_OUT: begin
                if (!stat.out_busy) begin
                    state_next = rdsf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rdsf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            rdsf_pkg::ST_IDLE: begin
                // no item is taken while reset is held
                s_tready = aresetn;
                cmd.load = s_tvalid && aresetn;
            end
            rdsf_pkg::ST_MUL: begin
                cmd.mul = 1'b1;
            end
            rdsf_pkg::ST_ACC: begin
                cmd.acc = 1'b1;
            end
            rdsf_pkg::ST_DINIT: begin
                cmd.div_init = 1'b1;
            end
            rdsf_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            rdsf_pkg::ST_OUT: begin
                cmd.finish = !stat.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/rdsf_datapath.sv
module rdsf_datapath #(
    parameter int INT_BITS        = 32,
    parameter int FRAC_BITS       = 32,
    parameter int MAX_FRAC_DIGITS = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  rdsf_pkg::radix_t         cfg_wdata,
    input  rdsf_pkg::char_t          s_tdata,
    input  logic                     s_tlast,
    input  rdsf_pkg::cmd_t           cmd,
    output rdsf_pkg::stat_t          stat,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [2*rdsf_pkg::OUT_W-1:0] m_tdata,
    output logic [1:0]               m_tuser
);

    localparam int PROD_W   = INT_BITS + rdsf_pkg::RADIX_W;
    localparam int DIVCNT_W = $clog2(FRAC_BITS);

    rdsf_pkg::radix_t    radix_reg;
    rdsf_pkg::char_t     char_reg;
    logic                last_reg;
    logic                point_reg;
    rdsf_pkg::digit_t    digit_reg;
    logic [INT_BITS-1:0] int_acc_reg;
    logic                after_point_reg;
    rdsf_pkg::frac_reg_t numer_reg;
    rdsf_pkg::frac_reg_t denom_reg;
    rdsf_pkg::fcnt_t     count_reg;
    logic                ovf_reg;
    logic                bad_reg;
    logic [PROD_W-1:0]   int_prod_reg;
    rdsf_pkg::frac_reg_t numer_prod_reg;
    rdsf_pkg::frac_reg_t denom_prod_reg;
    rdsf_pkg::frac_reg_t rem_reg;
    logic [FRAC_BITS-1:0] quot_reg;
    logic [DIVCNT_W-1:0] divcnt_reg;
    logic                m_tvalid_reg;
    rdsf_pkg::out_word_t out_int_reg;
    rdsf_pkg::out_word_t out_frac_reg;
    logic                out_ovf_reg;
    logic                out_bad_reg;

    rdsf_pkg::radix_t    radix_eff;
    rdsf_pkg::digit_t    digit_raw;
    logic                digit_bad;
    logic [PROD_W-1:0]   int_sum;
    logic [rdsf_pkg::FRAC_REG_W:0] rem_shift;
    logic [rdsf_pkg::FRAC_REG_W:0] denom_ext;
    logic                rem_ge;

    assign radix_eff = rdsf_pkg::clamp_radix(radix_reg);
    assign digit_raw = rdsf_pkg::digit_of(char_reg);
    assign digit_bad = (digit_raw >= radix_eff);
    assign int_sum   = int_prod_reg + PROD_W'(digit_reg);
    assign rem_shift = {rem_reg, 1'b0};
    assign denom_ext = {1'b0, denom_reg};
    assign rem_ge    = (rem_shift >= denom_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= rdsf_pkg::RADIX_RESET;
        end else if (cfg_we) begin
            radix_reg <= cfg_wdata;
        end
    end

    // item capture and products
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (cmd.mul) begin
            point_reg      <= (char_reg == rdsf_pkg::CHAR_POINT);
            digit_reg      <= digit_bad ? '0 : digit_raw;
            int_prod_reg   <= PROD_W'(int_acc_reg) * PROD_W'(radix_eff);
            numer_prod_reg <= rdsf_pkg::frac_reg_t'(numer_reg *
                                                     rdsf_pkg::frac_reg_t'(radix_eff));
            denom_prod_reg <= rdsf_pkg::frac_reg_t'(denom_reg *
                                                     rdsf_pkg::frac_reg_t'(radix_eff));
        end
    end

    // number state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.finish) begin
            int_acc_reg     <= '0;
            after_point_reg <= 1'b0;
            numer_reg       <= '0;
            denom_reg       <= rdsf_pkg::frac_reg_t'(1);
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            bad_reg         <= 1'b0;
        end else begin
            if (cmd.mul && digit_bad && (char_reg != rdsf_pkg::CHAR_POINT)) begin
                bad_reg <= 1'b1;
            end
            if (cmd.acc) begin
                if (point_reg) begin
                    after_point_reg <= 1'b1;
                end else if (!after_point_reg) begin
                    // anything above the integer width means saturation
                    if (int_sum[PROD_W-1:INT_BITS] != '0) begin
                        int_acc_reg <= '1;
                        ovf_reg     <= 1'b1;
                    end else begin
                        int_acc_reg <= int_sum[INT_BITS-1:0];
                    end
                end else if (count_reg < rdsf_pkg::fcnt_t'(MAX_FRAC_DIGITS)) begin
                    numer_reg <= numer_prod_reg + rdsf_pkg::frac_reg_t'(digit_reg);
                    denom_reg <= denom_prod_reg;
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg    <= numer_reg;
            quot_reg   <= '0;
            divcnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg    <= rem_ge ? rdsf_pkg::frac_reg_t'(rem_shift - denom_ext)
                                 : rem_shift[rdsf_pkg::FRAC_REG_W-1:0];
            quot_reg   <= {quot_reg[FRAC_BITS-2:0], rem_ge};
            divcnt_reg <= divcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_int_reg  <= rdsf_pkg::out_word_t'(int_acc_reg);
            out_frac_reg <= rdsf_pkg::out_word_t'(quot_reg);
            out_ovf_reg  <= ovf_reg;
            out_bad_reg  <= bad_reg;
        end
    end

    assign stat.last     = last_reg;
    assign stat.div_done = (divcnt_reg == DIVCNT_W'(FRAC_BITS - 1));
    assign stat.out_busy = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_frac_reg, out_int_reg};
    assign m_tuser  = {out_bad_reg, out_ovf_reg};

endmodule

// File: hdl/radix_digit_string_to_fixed_top.sv
// Converts a number written one ASCII character per item in a radix of 2 to 36
// (digits 0-9 and A-Z, '.' before the fraction) into a saturated integer part and
// an unsigned fixed-point fraction of FRAC_BITS bits, truncated. A character other
// than '.' that is not a digit or not below the radix counts as zero and sets
// bad_digit. Each character is captured, multiplied by the radix and accumulated;
// the character with tlast then goes on to a restoring divider that produces the
// fraction one quotient bit per cycle. The result sits in an output register, so
// characters of the next number are taken while it waits; only a second result
// stalls until the first has gone. The radix register resets to 10 and is written
// whenever cfg_we is high.
`include "radix_digit_string_to_fixed_top_assert.svh"

module radix_digit_string_to_fixed_top #(
    parameter int INT_BITS        = 32,
    parameter int FRAC_BITS       = 32,
    parameter int MAX_FRAC_DIGITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // int_value, frac_value
    output logic [1:0]  m_tuser    // overflow, bad_digit
);

    rdsf_pkg::cmd_t  cmd;
    rdsf_pkg::stat_t stat;

    rdsf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rdsf_datapath #(
        .INT_BITS        (INT_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // a captured item is always worked on before the next is taken
    `RDSF_ASSERT_NEXT(a_busy_after_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a result never overwrites one still waiting
    `RDSF_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.finish, !m_tvalid || m_tready)
    `RDSF_ASSERT_NEXT(a_result_shown, aclk, aresetn, cmd.finish, m_tvalid)
    // the divider only runs while no item can be taken
    `RDSF_ASSERT_SAME(a_div_blocks_input, aclk, aresetn, cmd.div_step, !s_tready)

endmodule
